@@ hw/rtl/mpsk_soft_bit_demapper_assert.svh @@
// assertion macros for the m-psk soft-bit demapper checker
// no dependencies; included by the checker file
`ifndef MPSK_SOFT_BIT_DEMAPPER_ASSERT_SVH
`define MPSK_SOFT_BIT_DEMAPPER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MPSK_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mpsk demapper assertion failed");

// next-cycle implication, disabled during reset
`define MPSK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mpsk demapper assertion failed");

// next-cycle implication that also holds through reset
`define MPSK_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mpsk demapper assertion failed");

`endif

@@ hw/rtl/mpsk_pkg.sv @@
// shared types, constants and tables for the m-psk soft-bit demapper
// no dependencies; used by the interfaces, the cordic stage, the top level, the checker and the testbench
`default_nettype none

package mpsk_pkg;

  // field widths
  localparam int IQ_W      = 16;
  localparam int MAP_W     = 8;
  localparam int K_W       = 4;
  localparam int W_W       = 16;
  localparam int SOFT_W    = 17;
  localparam int K_MAX     = 8;

  // cordic geometry
  localparam int ACC_W           = 32;
  localparam int XY_W            = 33;
  localparam int PRE_SHIFT       = 14;
  localparam int CORDIC_STEPS    = 32;
  localparam int STEPS_PER_STAGE = 4;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;

  // operation codes
  localparam logic OP_DEMAP     = 1'b0;
  localparam logic OP_MAP_WRITE = 1'b1;

  // bits_per_symbol limits and reset value
  localparam logic [K_W-1:0] K_RESET = 4'd2;
  localparam logic [K_W-1:0] K_LO    = 4'd1;
  localparam logic [K_W-1:0] K_HI    = 4'd8;

  // weight of 1.0 in q1.15
  localparam logic [W_W:0]              W_ONE    = 17'd32768;
  localparam logic signed [SOFT_W-1:0]  SOFT_MAX = 17'sd32768;
  localparam logic signed [SOFT_W-1:0]  SOFT_MIN = -17'sd32768;

  typedef logic signed [XY_W-1:0] xy_t;

  // rotating vector and phase accumulator
  typedef struct packed {
    xy_t              x;
    xy_t              y;
    logic [ACC_W-1:0] acc;
  } cordic_t;

  // item fields that ride alongside the cordic vector
  typedef struct packed {
    logic             opcode;
    logic             zero;
    logic [MAP_W-1:0] map_index;
    logic [MAP_W-1:0] map_value;
    logic [W_W-1:0]   w;
  } side_t;

  // atan(2^-s) in units of 2^-32 of a turn
  function automatic logic [ACC_W-1:0] atan_turn(input int s);
    case (s)
      0:       return 32'h2000_0000;
      1:       return 32'h12E4_051E;
      2:       return 32'h09FB_385B;
      3:       return 32'h0511_11D4;
      4:       return 32'h028B_0D43;
      5:       return 32'h0145_D7E1;
      6:       return 32'h00A2_F61E;
      7:       return 32'h0051_7C55;
      8:       return 32'h0028_BE53;
      9:       return 32'h0014_5F2F;
      10:      return 32'h000A_2F98;
      11:      return 32'h0005_17CC;
      12:      return 32'h0002_8BE6;
      13:      return 32'h0001_45F3;
      14:      return 32'h0000_A2FA;
      15:      return 32'h0000_517D;
      16:      return 32'h0000_28BE;
      17:      return 32'h0000_145F;
      18:      return 32'h0000_0A30;
      19:      return 32'h0000_0518;
      20:      return 32'h0000_028C;
      21:      return 32'h0000_0146;
      22:      return 32'h0000_00A3;
      23:      return 32'h0000_0051;
      24:      return 32'h0000_0029;
      25:      return 32'h0000_0014;
      26:      return 32'h0000_000A;
      27:      return 32'h0000_0005;
      28:      return 32'h0000_0003;
      29:      return 32'h0000_0001;
      30:      return 32'h0000_0001;
      default: return '0;
    endcase
  endfunction

  // low k bits set
  function automatic logic [K_MAX-1:0] bit_mask(input logic [K_W-1:0] k);
    logic [K_MAX-1:0] m;
    for (int b = 0; b < K_MAX; b++) begin
      m[b] = (b < int'(k));
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mpsk_if.sv @@
// valid/ready channel interfaces for sample items and soft-bit results
// depends on mpsk_pkg
`default_nettype none

// sample or map-write item
interface mpsk_item_if import mpsk_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    opcode;
  logic signed [IQ_W-1:0]  in_i;
  logic signed [IQ_W-1:0]  in_q;
  logic [MAP_W-1:0]        map_index;
  logic [MAP_W-1:0]        map_value;

  modport source(output valid, opcode, in_i, in_q, map_index, map_value, input ready);
  modport sink(input valid, opcode, in_i, in_q, map_index, map_value, output ready);
endinterface

// one soft bit per beat
interface mpsk_result_if import mpsk_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SOFT_W-1:0] soft_bit;
  logic                     last_bit;

  modport source(output valid, soft_bit, last_bit, input ready);
  modport sink(input valid, soft_bit, last_bit, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mpsk_cordic_stage.sv @@
// one register stage of the vectoring cordic: a fixed run of micro-rotations
// depends on mpsk_pkg; instantiated by mpsk_soft_bit_demapper
`default_nettype none

module mpsk_cordic_stage import mpsk_pkg::*; #(
  parameter int FIRST = 0
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    up_valid,
  input  cordic_t up_vec,
  input  side_t   up_side,
  output logic    up_ready,
  output logic    dn_valid,
  output cordic_t dn_vec,
  output side_t   dn_side,
  input  logic    dn_ready
);

  cordic_t vec_next;

  // micro-rotations FIRST .. FIRST+STEPS_PER_STAGE-1, driving y towards zero
  always_comb begin
    cordic_t v;
    xy_t     dx;
    xy_t     dy;
    v = up_vec;
    for (int n = 0; n < STEPS_PER_STAGE; n++) begin
      dx = $signed(v.y) >>> (FIRST + n);
      dy = $signed(v.x) >>> (FIRST + n);
      if ($signed(v.y) > 0) begin
        v.x   = v.x + dx;
        v.y   = v.y - dy;
        v.acc = v.acc + atan_turn(FIRST + n);
      end else begin
        v.x   = v.x - dx;
        v.y   = v.y + dy;
        v.acc = v.acc - atan_turn(FIRST + n);
      end
    end
    vec_next = v;
  end

  assign up_ready = !dn_valid || dn_ready;

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_vec  <= vec_next;
      dn_side <= up_side;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mpsk_soft_bit_demapper.sv @@
// m-psk soft-bit demapper: cordic phase, sector rounding, symbol map lookup, soft-bit serialiser
// depends on mpsk_pkg, mpsk_if and mpsk_cordic_stage
// path: the first soft bit reaches result through 14 registers: stage 0, cordic stages 1 to 8,
//   stages 9 to 12 and the serialiser; one input beat per cycle enters while no stage stalls;
//   a sample holds the result port for k = bits_per_symbol beats, map writes one per cycle unstalled
// reset: clears all valid bits and sets bits_per_symbol to 2; the symbol map is not cleared
`default_nettype none

module mpsk_soft_bit_demapper import mpsk_pkg::*; #(
  parameter int PHASE_BITS = 16,
  parameter int MAP_DEPTH  = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [K_W-1:0] cfg_data,
  mpsk_item_if.sink      item,
  mpsk_result_if.source  result
);

  localparam int               PROD_W  = PHASE_BITS + K_MAX;
  localparam int               AW      = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam logic [K_MAX:0]   DEPTH_C = (K_MAX + 1)'(MAP_DEPTH);
  localparam logic [PROD_W-1:0] HALF   = PROD_W'(1) << (PHASE_BITS - 1);

  // reciprocal of the map depth, exact for every 8-bit sector
  localparam int                   RECIP_SHIFT = 2 * K_MAX;
  localparam logic [RECIP_SHIFT:0] RECIP       =
    (RECIP_SHIFT + 1)'((2 ** RECIP_SHIFT + MAP_DEPTH - 1) / MAP_DEPTH);

  // configuration
  logic [K_W-1:0] bits_per_symbol;
  logic [K_W-1:0] k_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_symbol <= K_RESET;
    end else if (cfg_we) begin
      bits_per_symbol <= cfg_data;
    end
  end

  // clamp k to 1..8
  always_comb begin
    if (bits_per_symbol < K_LO) begin
      k_eff = K_LO;
    end else if (bits_per_symbol > K_HI) begin
      k_eff = K_HI;
    end else begin
      k_eff = bits_per_symbol;
    end
  end

  // stage handshakes
  logic    st_valid [CORDIC_STAGES+1];
  logic    st_ready [CORDIC_STAGES+1];
  cordic_t st_vec   [CORDIC_STAGES+1];
  side_t   st_side  [CORDIC_STAGES+1];
  logic    s10_ready;
  logic    s11_ready;
  logic    s12_ready;

  // stage 0: pre-rotation into the right half plane and the two squares
  logic                   s0_valid;
  logic                   s0_ready;
  cordic_t                s0_vec;
  logic                   s0_op;
  logic                   s0_zero;
  logic [MAP_W-1:0]       s0_idx;
  logic [MAP_W-1:0]       s0_val;
  logic [2*IQ_W-2:0]      s0_sqi;
  logic [2*IQ_W-2:0]      s0_sqq;

  cordic_t                pre_vec;
  logic signed [2*IQ_W-1:0] prod_i;
  logic signed [2*IQ_W-1:0] prod_q;

  always_comb begin
    xy_t xi;
    xy_t yq;
    xi = {{(XY_W - IQ_W - PRE_SHIFT){item.in_i[IQ_W-1]}}, item.in_i, {PRE_SHIFT{1'b0}}};
    yq = {{(XY_W - IQ_W - PRE_SHIFT){item.in_q[IQ_W-1]}}, item.in_q, {PRE_SHIFT{1'b0}}};
    if (item.in_i[IQ_W-1]) begin
      pre_vec.x   = -xi;
      pre_vec.y   = -yq;
      pre_vec.acc = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      pre_vec.x   = xi;
      pre_vec.y   = yq;
      pre_vec.acc = '0;
    end
  end

  assign prod_i     = item.in_i * item.in_i;
  assign prod_q     = item.in_q * item.in_q;
  assign s0_ready   = !s0_valid || st_ready[0];
  assign item.ready = s0_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_ready) begin
      s0_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && s0_ready) begin
      s0_vec  <= pre_vec;
      s0_op   <= item.opcode;
      s0_zero <= (item.in_i == '0) && (item.in_q == '0);
      s0_idx  <= item.map_index;
      s0_val  <= item.map_value;
      s0_sqi  <= prod_i[2*IQ_W-2:0];
      s0_sqq  <= prod_q[2*IQ_W-2:0];
    end
  end

  // weight: (i^2 + q^2) / 2^15, capped at 1.0
  logic [2*IQ_W-1:0] energy;
  logic [W_W:0]      w_raw;
  logic [W_W-1:0]    w_sat;

  assign energy = {1'b0, s0_sqi} + {1'b0, s0_sqq};
  assign w_raw  = energy[2*IQ_W-1:15];
  assign w_sat  = (w_raw > W_ONE) ? W_ONE[W_W-1:0] : w_raw[W_W-1:0];

  // cordic pipeline, stages 1 to 8
  assign st_valid[0] = s0_valid;
  assign st_vec[0]   = s0_vec;
  assign st_side[0]  = '{opcode: s0_op, zero: s0_zero, map_index: s0_idx,
                         map_value: s0_val, w: w_sat};

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    mpsk_cordic_stage #(
      .FIRST(g * STEPS_PER_STAGE)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (st_valid[g]),
      .up_vec   (st_vec[g]),
      .up_side  (st_side[g]),
      .up_ready (st_ready[g]),
      .dn_valid (st_valid[g+1]),
      .dn_vec   (st_vec[g+1]),
      .dn_side  (st_side[g+1]),
      .dn_ready (st_ready[g+1])
    );
  end

  // stage 9: phase and phase * M
  logic                  s9_valid;
  logic                  s9_ready;
  logic [PROD_W-1:0]     s9_prod;
  side_t                 s9_side;
  logic [PHASE_BITS-1:0] phase;

  assign phase = st_side[CORDIC_STAGES].zero ? '0
               : st_vec[CORDIC_STAGES].acc[ACC_W-1 -: PHASE_BITS];
  assign s9_ready = !s9_valid || s10_ready;
  assign st_ready[CORDIC_STAGES] = s9_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_valid <= 1'b0;
    end else if (s9_ready) begin
      s9_valid <= st_valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (st_valid[CORDIC_STAGES] && s9_ready) begin
      s9_prod <= {{K_MAX{1'b0}}, phase} << k_eff;
      s9_side <= st_side[CORDIC_STAGES];
    end
  end

  // stage 10: round to nearest sector, modulo M
  logic              s10_valid;
  logic [K_MAX-1:0]  s10_sector;
  side_t             s10_side;
  logic [PROD_W-1:0] rounded;

  assign rounded   = s9_prod + HALF;
  assign s10_ready = !s10_valid || s11_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s10_valid <= 1'b0;
    end else if (s10_ready) begin
      s10_valid <= s9_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s9_valid && s10_ready) begin
      s10_sector <= rounded[PROD_W-1 -: K_MAX] & bit_mask(k_eff);
      s10_side   <= s9_side;
    end
  end

  // stage 11: map address, sector reduced modulo the map depth
  logic                             s11_valid;
  logic [AW-1:0]                    s11_addr;
  logic                             s11_op;
  logic                             s11_wr_ok;
  logic [MAP_W-1:0]                 s11_val;
  logic [W_W-1:0]                   s11_w;
  logic [K_MAX:0]                   sector_rem;
  logic [K_MAX+RECIP_SHIFT-1:0]     quot_prod;
  logic [K_MAX-1:0]                 sector_quot;
  logic [K_MAX:0]                   quot_depth;

  // quotient by reciprocal multiplication, then sector minus quotient times depth
  assign quot_prod   = (K_MAX + RECIP_SHIFT)'(s10_sector) * (K_MAX + RECIP_SHIFT)'(RECIP);
  assign sector_quot = quot_prod[K_MAX+RECIP_SHIFT-1 -: K_MAX];
  assign quot_depth  = (K_MAX + 1)'(sector_quot) * DEPTH_C;
  assign sector_rem  = {1'b0, s10_sector} - quot_depth;

  assign s11_ready = !s11_valid || s12_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s11_valid <= 1'b0;
    end else if (s11_ready) begin
      s11_valid <= s10_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s10_valid && s11_ready) begin
      s11_op    <= s10_side.opcode;
      s11_wr_ok <= ({1'b0, s10_side.map_index} < DEPTH_C);
      s11_val   <= s10_side.map_value;
      s11_w     <= s10_side.w;
      if (s10_side.opcode == OP_MAP_WRITE) begin
        s11_addr <= s10_side.map_index[AW-1:0];
      end else begin
        s11_addr <= sector_rem[AW-1:0];
      end
    end
  end

  // stage 12: symbol map access in item order; map writes end here
  logic             s12_valid;
  logic [MAP_W-1:0] s12_data;
  logic [W_W-1:0]   s12_w;
  logic [MAP_W-1:0] symbol_map [MAP_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      s12_valid <= 1'b0;
    end else if (s12_ready) begin
      s12_valid <= s11_valid && (s11_op == OP_DEMAP);
    end
  end

  always_ff @(posedge clk) begin
    if (s11_valid && s12_ready) begin
      if (s11_op == OP_MAP_WRITE) begin
        if (s11_wr_ok) begin
          symbol_map[s11_addr] <= s11_val;
        end
      end else begin
        s12_data <= symbol_map[s11_addr];
        s12_w    <= s11_w;
      end
    end
  end

  // serialiser: one soft bit per beat, msb first
  logic                     ser_valid;
  logic                     ser_load;
  logic [K_W-1:0]           ser_cnt;
  logic [K_MAX-1:0]         ser_pat;
  logic signed [SOFT_W-1:0] ser_wp;
  logic signed [SOFT_W-1:0] ser_wn;

  assign ser_load  = !ser_valid || (result.ready && (ser_cnt == K_LO));
  assign s12_ready = !s12_valid || ser_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_cnt   <= '0;
    end else if (ser_load) begin
      ser_valid <= s12_valid;
      ser_cnt   <= k_eff;
    end else if (result.ready) begin
      ser_cnt   <= ser_cnt - K_LO;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load && s12_valid) begin
      ser_pat <= s12_data << (K_HI - k_eff);
      ser_wp  <= $signed({1'b0, s12_w});
      ser_wn  <= -$signed({1'b0, s12_w});
    end else if (ser_valid && result.ready) begin
      ser_pat <= {ser_pat[K_MAX-2:0], 1'b0};
    end
  end

  assign result.valid    = ser_valid;
  assign result.soft_bit = ser_pat[K_MAX-1] ? ser_wp : ser_wn;
  assign result.last_bit = (ser_cnt == K_LO);

endmodule

`default_nettype wire

@@ hw/rtl/mpsk_demap_checker.sv @@
// port-level checker for the m-psk soft-bit demapper, bound to the top level
// depends on mpsk_pkg and mpsk_soft_bit_demapper_assert.svh
`default_nettype none

`include "mpsk_soft_bit_demapper_assert.svh"

module mpsk_demap_checker import mpsk_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     res_valid,
  input logic                     res_ready,
  input logic signed [SOFT_W-1:0] soft_bit,
  input logic                     last_bit
);

  // a stalled result beat keeps its value
  `MPSK_ASSERT_NEXT(a_stall_holds, clk, rst, res_valid && !res_ready, res_valid && $stable(soft_bit) && $stable(last_bit))

  // weight magnitude never exceeds 1.0
  `MPSK_ASSERT_NOW(a_weight_capped, clk, rst, res_valid, (soft_bit <= SOFT_MAX) && (soft_bit >= SOFT_MIN))

  // a symbol's beats come without gaps and share one magnitude
  `MPSK_ASSERT_NEXT(a_symbol_contiguous, clk, rst, res_valid && res_ready && !last_bit, res_valid && ((soft_bit == $past(soft_bit)) || (soft_bit == -$past(soft_bit))))

  // nothing leaves the block straight after reset
  `MPSK_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !res_valid)

endmodule

bind mpsk_soft_bit_demapper mpsk_demap_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .soft_bit  (result.soft_bit),
  .last_bit  (result.last_bit)
);

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for the m-psk soft-bit demapper: own cordic phase, sector and weight
// predictor, random beat gaps on both channels, long result stalls and bits_per_symbol sweeps
// depends on mpsk_pkg, mpsk_if and the demapper rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mpsk_pkg::*;

  localparam int PHASE_BITS    = 16;
  localparam int MAP_DEPTH     = 256;
  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_PRINTS    = 30;
  localparam int TIMEOUT_NS    = 2_000_000;

  // atan(2^-s) as a fraction of a turn, scaled by 2^32
  localparam logic [0:31][31:0] ATAN_TURN = {
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
    32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
  };

  typedef struct {
    logic                   opcode;
    logic signed [IQ_W-1:0] in_i;
    logic signed [IQ_W-1:0] in_q;
    logic [MAP_W-1:0]       map_index;
    logic [MAP_W-1:0]       map_value;
  } sample_beat_t;

  typedef struct {
    logic signed [SOFT_W-1:0] soft_bit;
    logic                     last_bit;
  } soft_bit_t;

  logic           clk;
  logic           rst;
  logic           cfg_we;
  logic [K_W-1:0] cfg_data;

  mpsk_item_if   item_ch ();
  mpsk_result_if result_ch ();

  mpsk_soft_bit_demapper DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .item(item_ch),
    .result(result_ch)
  );

  // predictor state
  logic [MAP_W-1:0] sym_map [MAP_DEPTH];
  logic [K_W-1:0]   bits_per_sym;
  soft_bit_t        pending_bits [$];
  soft_bit_t        next_bit;

  // run control and bookkeeping
  bit tx_idle;
  bit rx_idle;
  int hold_left;
  int stall_left;
  int error_count;
  int demap_count;
  int write_count;
  int bits_checked;
  int settings_used;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // vectoring cordic phase, PHASE_BITS wide
  function automatic logic [PHASE_BITS-1:0] beat_phase(input logic signed [IQ_W-1:0] si,
                                                       input logic signed [IQ_W-1:0] sq);
    longint      x;
    longint      y;
    longint      dx;
    longint      dy;
    logic [31:0] acc;
    if (si == 0 && sq == 0) return '0;
    x = longint'(si) * 16384;
    y = longint'(sq) * 16384;
    acc = 32'h0;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = 32'h8000_0000;
    end
    for (int s = 0; s < 32; s++) begin
      dx = y >>> s;
      dy = x >>> s;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        acc = acc + ATAN_TURN[s];
      end else begin
        x = x - dx;
        y = y + dy;
        acc = acc - ATAN_TURN[s];
      end
    end
    return acc[31:32-PHASE_BITS];
  endfunction

  // apply one accepted beat to the map copy, or queue the soft bits it must produce
  function automatic void predict_soft_bits(input sample_beat_t b);
    logic [PHASE_BITS-1:0] phase;
    int                    k;
    int                    sector;
    longint                energy;
    longint                w;
    longint                soft_val;
    logic [MAP_W-1:0]      pattern;
    soft_bit_t             r;
    if (b.opcode == OP_MAP_WRITE) begin
      if (int'(b.map_index) < MAP_DEPTH) sym_map[b.map_index] = b.map_value;
      write_count++;
      return;
    end
    demap_count++;
    k = int'(bits_per_sym);
    if (k < 1) k = 1;
    if (k > 8) k = 8;
    phase = beat_phase(b.in_i, b.in_q);
    sector = ((int'(phase) << k) + (1 << (PHASE_BITS - 1))) >> PHASE_BITS;
    sector = sector & ((1 << k) - 1);
    pattern = sym_map[sector % MAP_DEPTH];
    energy = longint'(b.in_i) * longint'(b.in_i) + longint'(b.in_q) * longint'(b.in_q);
    w = energy >>> 15;
    if (w > 32768) w = 32768;
    for (int j = 0; j < k; j++) begin
      soft_val = pattern[k-1-j] ? w : -w;
      r.soft_bit = soft_val[SOFT_W-1:0];
      r.last_bit = (j == k - 1);
      pending_bits.push_back(r);
    end
  endfunction

  // one input beat: optional gap, then hold until accepted; returns just after the edge
  task automatic send_item(input sample_beat_t b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
    end
    @(negedge clk);
    item_ch.valid     <= 1'b1;
    item_ch.opcode    <= b.opcode;
    item_ch.in_i      <= b.in_i;
    item_ch.in_q      <= b.in_q;
    item_ch.map_index <= b.map_index;
    item_ch.map_value <= b.map_value;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    predict_soft_bits(b);
  endtask

  task automatic send_demap(input logic signed [IQ_W-1:0] si, input logic signed [IQ_W-1:0] sq);
    sample_beat_t b;
    b.opcode    = OP_DEMAP;
    b.in_i      = si;
    b.in_q      = sq;
    b.map_index = MAP_W'($urandom);
    b.map_value = MAP_W'($urandom);
    send_item(b);
  endtask

  task automatic send_map_write(input logic [MAP_W-1:0] idx, input logic [MAP_W-1:0] val);
    sample_beat_t b;
    b.opcode    = OP_MAP_WRITE;
    b.in_i      = IQ_W'($urandom);
    b.in_q      = IQ_W'($urandom);
    b.map_index = idx;
    b.map_value = val;
    send_item(b);
  endtask

  // sample component biased towards extremes and small magnitudes
  function automatic logic signed [IQ_W-1:0] random_component();
    logic signed [IQ_W-1:0] v;
    v = IQ_W'($urandom);
    case ($urandom_range(0, 15))
      0:          v = 16'h7FFF;
      1:          v = 16'h8000;
      2:          v = 16'h0000;
      3:          v = 16'hFFFF;
      4, 5, 6, 7: v = v >>> $urandom_range(1, 10);
      default:    ;
    endcase
    return v;
  endfunction

  task automatic send_random_item();
    if ($urandom_range(0, 99) < 15) send_map_write(MAP_W'($urandom), MAP_W'($urandom));
    else send_demap(random_component(), random_component());
  endtask

  // stop offering, wait for every pending soft bit, then let the pipeline empty
  task automatic wait_drained();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (pending_bits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_bits_per_symbol(input logic [K_W-1:0] k);
    wait_drained();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= k;
    @(posedge clk);
    bits_per_sym = k;
    settings_used++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // every entry gets a value first so that no demap reads an unwritten sector
  task automatic load_symbol_map();
    for (int n = 0; n < MAP_DEPTH; n++) send_map_write(n[MAP_W-1:0], MAP_W'($urandom));
  endtask

  // extremes, axes, sector boundaries, wrap, zero, saturated weight, ignored fields
  task automatic test_directed();
    send_demap(16'sh0000, 16'sh0000);
    send_demap(16'sh7FFF, 16'sh0000);
    send_demap(16'sh0000, 16'sh7FFF);
    send_demap(16'h8000, 16'sh0000);
    send_demap(16'sh0000, 16'h8000);
    send_demap(16'h8000, 16'h8000);
    send_demap(16'sh7FFF, 16'sh7FFF);
    send_demap(16'shFFFF, 16'shFFFF);
    send_demap(16'sh5A82, 16'sh5A82);
    send_demap(16'h8000, 16'sh0001);
    send_demap(16'sh7FFF, 16'shFFFF);
    send_map_write(8'd0, 8'hA6);
    send_map_write(8'd255, 8'hFF);
    send_map_write(8'd1, 8'h00);
    send_demap(16'sh0000, 16'sh0000);
    set_bits_per_symbol(4'd8);
    send_demap(16'sh7FFF, -16'sd800);
    send_demap(16'sh7FFF, 16'shFFFF);
    send_demap(16'h8000, 16'h8000);
    send_demap(16'sh0000, 16'sh0000);
    send_demap(16'sh3039, -16'sd23456);
    set_bits_per_symbol(4'd1);
    send_demap(16'sh0000, 16'sh7FFF);
    send_demap(16'sh0000, 16'h8000);
  endtask

  // walk bits_per_symbol through its range, out-of-range codes included
  task automatic test_config_sweep();
    logic [K_W-1:0] order [11] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd4, 4'd6, 4'd7,
                                   4'd9, 4'd2};
    foreach (order[n]) begin
      set_bits_per_symbol(order[n]);
      tx_idle = (n % 3 != 0);
      rx_idle = (n % 4 != 1);
      repeat (8) send_random_item();
    end
  endtask

  // result side stalls for a long stretch while items keep coming
  task automatic test_backpressure();
    set_bits_per_symbol(4'd8);
    tx_idle   = 1'b0;
    rx_idle   = 1'b1;
    hold_left = 400;
    repeat (30) send_random_item();
  endtask

  // sender goes quiet until every soft bit has come back, then resumes
  task automatic test_sender_pause();
    set_bits_per_symbol(4'd3);
    tx_idle = 1'b1;
    repeat (10) send_random_item();
    wait_drained();
    repeat (10) send_random_item();
  endtask

  // random chunks, each with its own setting and idling mix
  task automatic test_random();
    for (int c = 0; c < 6; c++) begin
      set_bits_per_symbol(K_W'($urandom_range(0, 15)));
      tx_idle = 1'($urandom_range(0, 1));
      rx_idle = 1'($urandom_range(0, 1));
      repeat (7) send_random_item();
    end
  endtask

  // result ready: long hold first, then the per-beat stall
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      result_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // compare each soft bit beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      stall_left = rx_idle ? $urandom_range(0, 3) : 0;
      if (pending_bits.size() == 0) begin
        report_mismatch($sformatf("soft bit %0d with nothing pending", result_ch.soft_bit));
      end else begin
        next_bit = pending_bits.pop_front();
        bits_checked++;
        if (result_ch.soft_bit !== next_bit.soft_bit)
          report_mismatch($sformatf("soft_bit %0d, predicted %0d",
                                    result_ch.soft_bit, next_bit.soft_bit));
        if (result_ch.last_bit !== next_bit.last_bit)
          report_mismatch($sformatf("last_bit %b, predicted %b",
                                    result_ch.last_bit, next_bit.last_bit));
      end
    end
  end

  initial begin
    #TIMEOUT_NS;
    $display("timeout with %0d soft bits pending", pending_bits.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    item_ch.valid       = 1'b0;
    item_ch.opcode      = OP_DEMAP;
    item_ch.in_i        = '0;
    item_ch.in_q        = '0;
    item_ch.map_index   = '0;
    item_ch.map_value   = '0;
    result_ch.ready     = 1'b0;
    bits_per_sym        = K_RESET;
    tx_idle             = 1'b1;
    rx_idle             = 1'b1;
    hold_left           = 0;
    stall_left          = 0;
    error_count         = 0;
    demap_count         = 0;
    write_count         = 0;
    bits_checked        = 0;
    settings_used       = 0;
    foreach (sym_map[n]) sym_map[n] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_symbol_map();
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_sender_pause();
    test_random();
    wait_drained();

    if (pending_bits.size() != 0)
      report_mismatch($sformatf("%0d soft bits never arrived", pending_bits.size()));
    $display("demapped %0d samples and applied %0d map writes, %0d soft bits checked",
             demap_count, write_count, bits_checked);
    $display("%0d bits_per_symbol writes, long result stall and sender pause included",
             settings_used);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ mpsk_soft_bit_demapper.f @@
+incdir+hw/rtl
hw/rtl/mpsk_pkg.sv
hw/rtl/mpsk_if.sv
hw/rtl/mpsk_cordic_stage.sv
hw/rtl/mpsk_soft_bit_demapper.sv
hw/rtl/mpsk_demap_checker.sv
tb/testbench.sv
